>>> sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// Session frame parser package
// Frame types, lengths, verdict codes, header phases and register indexes
// shared by the session frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int MAX_PLAYERS   = 4;
    localparam int RECV_CAPACITY = 8192;

    // Payload bytes kept for decoding; later bytes are only counted.
    localparam int STORE_DEPTH = 25;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int PLAYER_W    = $clog2(MAX_PLAYERS);

    localparam logic [8:0]  MAX_PLAYERS_W = 9'(MAX_PLAYERS);
    localparam logic [17:0] CAPACITY_W    = 18'(RECV_CAPACITY);
    localparam logic [17:0] HEADER_BYTES  = 18'd3;

    localparam logic [7:0] TYPE_HELLO = 8'd1;
    localparam logic [7:0] TYPE_POSE  = 8'd2;
    localparam logic [7:0] TYPE_EDIT  = 8'd3;
    localparam logic [7:0] TYPE_LEAVE = 8'd4;

    localparam logic [15:0] HELLO_SIZE = 16'd23;
    localparam logic [15:0] POSE_SIZE  = 16'd25;
    localparam logic [15:0] EDIT_SIZE  = 16'd16;
    localparam logic [15:0] LEAVE_SIZE = 16'd1;

    localparam logic [2:0] CFG_CLIENT_MODE      = 3'd0;
    localparam logic [2:0] CFG_LINK_PLAYER_ID   = 3'd1;
    localparam logic [2:0] CFG_EXPECTED_MAGIC   = 3'd2;
    localparam logic [2:0] CFG_PROTOCOL_VERSION = 3'd3;
    localparam logic [2:0] CFG_GAME_BUILD       = 3'd4;
    localparam logic [2:0] CFG_GENERATOR_BUILD  = 3'd5;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [3:0] {
        V_HELLO_OK,
        V_POSE,
        V_EDIT,
        V_LEAVE_CLEAR,
        V_LEAVE_IGNORED,
        V_BAD_LENGTH,
        V_UNKNOWN_TYPE,
        V_OVERSIZE,
        V_VERSION_REFUSED,
        V_HELLO_BAD_ID,
        V_POSE_BAD_ID,
        V_HELLO_WRONG_MODE
    } verdict_t;

endpackage

>>> sv/session_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Session frame parser core
// Parses the received link byte stream into frames and gives one verdict
// per complete frame, or per oversize header, on a live link.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one received byte per
//   request together with a link_restart flag that starts a new link before
//   that byte is parsed. The output channel (out_valid/out_ready) carries
//   one verdict request per complete frame, or per oversize header, on a live link.
//   Configuration registers are written through cfg_write/cfg_index/cfg_data;
//   the user must write them only while the link is idle, as the block does not enforce it.
//   Throughput is one byte per cycle while no verdict byte is held back. A
//   byte is registered on acceptance, parsed in the following cycle against
//   the running header state, and its verdict is loaded into the output
//   register, which raises out_valid, at the end of the cycle in which it advances.
//   A byte that gives no verdict moves on even while the output waits; a byte
//   that gives a verdict waits in the input register until the output
//   register is free, and in_ready drops while it waits.
//   Reset clears the parser, the drop and failure marks, the local id and
//   all configuration registers. Payload storage is not cleared.
// ----------------------------------------------------------------------------
module session_frame_parser_core
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        link_restart,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  verdict,
    output logic [7:0]  player_id,
    output logic [31:0] word_a,
    output logic [31:0] word_b,
    output logic [31:0] word_c,
    output logic [31:0] word_d,
    output logic [31:0] word_e,
    output logic [31:0] word_f,
    output logic [63:0] world_seed,
    output logic        relay,
    output logic        link_dropped,
    output logic        session_failed
);

    // Configuration registers.
    logic        client_mode_reg;
    logic [1:0]  link_player_id_reg;
    logic [31:0] expected_magic_reg;
    logic [15:0] protocol_version_reg;
    logic [31:0] game_build_reg;
    logic [31:0] generator_build_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic        dead_reg, dead_next;
    logic        failed_reg, failed_next;
    logic [PLAYER_W-1:0] local_id_reg, local_id_next;
    logic        local_valid_reg, local_valid_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    // Result register.
    logic        out_valid_reg;
    verdict_t    verdict_reg, r_verdict;
    logic [7:0]  player_id_reg, r_player_id;
    logic [31:0] word_a_reg, word_b_reg, word_c_reg, word_d_reg, word_e_reg, word_f_reg;
    logic [31:0] r_word_a, r_word_b, r_word_c, r_word_d, r_word_e, r_word_f;
    logic [63:0] world_seed_reg, r_world_seed;
    logic        relay_reg, r_relay;
    logic        dropped_reg, failed_out_reg;

    logic        advance;
    logic        has_result;
    logic        decide_now;
    logic        store_we;
    logic [15:0] count_plus;
    logic [15:0] len_full;
    logic [15:0] dec_len;
    phase_t      eff_phase;
    logic        eff_dead;
    logic [STORE_DEPTH*8-1:0] view_flat;
    logic [7:0]  hello_id;
    logic [7:0]  pose_id;
    logic [7:0]  leave_id;
    logic        leave_is_local;

    // A byte with no verdict may pass even while the output register is full.
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign count_plus = count_reg + 16'd1;

    // The payload as the decoder sees it: stored bytes with the byte being
    // written this cycle folded in.
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (store_we && count_reg[STORE_IDX_W-1:0] == STORE_IDX_W'(i))
            begin
                view_flat[8*i +: 8] = in_byte_reg;
            end
            else
            begin
                view_flat[8*i +: 8] = store_reg[i];
            end
        end
    end

    assign hello_id = view_flat[8*22 +: 8];
    assign pose_id  = client_mode_reg ? view_flat[7:0] : {6'd0, link_player_id_reg};
    assign leave_id = view_flat[7:0];

    always_comb
    begin
        if (client_mode_reg)
        begin
            leave_is_local = local_valid_reg
                && leave_id[PLAYER_W-1:0] == local_id_reg
                && {1'b0, leave_id} < MAX_PLAYERS_W;
        end
        else
        begin
            leave_is_local = (leave_id == 8'd0);
        end
    end

    // Next state of the parser and the verdict of the byte in the input register.
    always_comb
    begin
        phase_next       = phase_reg;
        type_next        = type_reg;
        len_next         = len_reg;
        count_next       = count_reg;
        dead_next        = dead_reg;
        failed_next      = failed_reg;
        local_id_next    = local_id_reg;
        local_valid_next = local_valid_reg;
        store_we         = 1'b0;
        decide_now       = 1'b0;
        has_result       = 1'b0;
        dec_len          = len_reg;
        len_full         = {in_byte_reg, len_reg[7:0]};
        r_verdict        = V_HELLO_OK;
        r_player_id      = 8'd0;
        r_word_a         = 32'd0;
        r_word_b         = 32'd0;
        r_word_c         = 32'd0;
        r_word_d         = 32'd0;
        r_word_e         = 32'd0;
        r_word_f         = 32'd0;
        r_world_seed     = 64'd0;
        r_relay          = 1'b0;

        // A restart clears the parser and both marks before the byte is parsed.
        eff_phase  = in_restart_reg ? PH_TYPE : phase_reg;
        eff_dead   = in_restart_reg ? 1'b0 : dead_reg;

        if (in_valid_reg)
        begin
            if (in_restart_reg)
            begin
                phase_next  = PH_TYPE;
                type_next   = 8'd0;
                len_next    = 16'd0;
                count_next  = 16'd0;
                dead_next   = 1'b0;
                failed_next = 1'b0;
            end
            if (!eff_dead)
            begin
                unique case (eff_phase)
                    PH_TYPE:
                    begin
                        type_next  = in_byte_reg;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_next   = {8'd0, in_byte_reg};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        len_next   = len_full;
                        count_next = 16'd0;
                        if (18'(len_full) + HEADER_BYTES > CAPACITY_W)
                        begin
                            has_result = 1'b1;
                            r_verdict  = V_OVERSIZE;
                            dead_next  = 1'b1;
                            phase_next = PH_TYPE;
                            type_next  = 8'd0;
                            len_next   = 16'd0;
                        end
                        else if (len_full == 16'd0)
                        begin
                            decide_now = 1'b1;
                            dec_len    = 16'd0;
                            phase_next = PH_TYPE;
                            type_next  = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        store_we   = (count_reg < 16'(STORE_DEPTH));
                        count_next = count_plus;
                        if (count_plus == len_reg)
                        begin
                            decide_now = 1'b1;
                            phase_next = PH_TYPE;
                            type_next  = 8'd0;
                            len_next   = 16'd0;
                            count_next = 16'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TYPE;
                    end
                endcase
            end
        end

        if (decide_now)
        begin
            has_result = 1'b1;
            unique case (type_reg)
                TYPE_HELLO:
                begin
                    if (!client_mode_reg)
                    begin
                        r_verdict = V_HELLO_WRONG_MODE;
                        dead_next = 1'b1;
                    end
                    else if (dec_len != HELLO_SIZE)
                    begin
                        r_verdict = V_BAD_LENGTH;
                        dead_next = 1'b1;
                    end
                    else if (view_flat[8*0 +: 32] != expected_magic_reg
                        || view_flat[8*4 +: 16] != protocol_version_reg
                        || view_flat[8*6 +: 32] != game_build_reg
                        || view_flat[8*10 +: 32] != generator_build_reg)
                    begin
                        r_verdict   = V_VERSION_REFUSED;
                        dead_next   = 1'b1;
                        failed_next = 1'b1;
                    end
                    else if (hello_id == 8'd0 || {1'b0, hello_id} >= MAX_PLAYERS_W)
                    begin
                        r_verdict   = V_HELLO_BAD_ID;
                        r_player_id = hello_id;
                        dead_next   = 1'b1;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        r_verdict        = V_HELLO_OK;
                        r_player_id      = hello_id;
                        r_world_seed     = view_flat[8*14 +: 64];
                        local_id_next    = hello_id[PLAYER_W-1:0];
                        local_valid_next = 1'b1;
                    end
                end
                TYPE_POSE:
                begin
                    if (dec_len != POSE_SIZE)
                    begin
                        r_verdict = V_BAD_LENGTH;
                        dead_next = 1'b1;
                    end
                    else if ({1'b0, pose_id} >= MAX_PLAYERS_W)
                    begin
                        r_verdict   = V_POSE_BAD_ID;
                        r_player_id = pose_id;
                        dead_next   = 1'b1;
                    end
                    else
                    begin
                        r_verdict   = V_POSE;
                        r_player_id = pose_id;
                        r_word_a    = view_flat[8*1 +: 32];
                        r_word_b    = view_flat[8*5 +: 32];
                        r_word_c    = view_flat[8*9 +: 32];
                        r_word_d    = view_flat[8*13 +: 32];
                        r_word_e    = view_flat[8*17 +: 32];
                        r_word_f    = view_flat[8*21 +: 32];
                        r_relay     = !client_mode_reg;
                    end
                end
                TYPE_EDIT:
                begin
                    if (dec_len != EDIT_SIZE)
                    begin
                        r_verdict = V_BAD_LENGTH;
                        dead_next = 1'b1;
                    end
                    else
                    begin
                        r_verdict = V_EDIT;
                        r_word_a  = view_flat[8*0 +: 32];
                        r_word_b  = view_flat[8*4 +: 32];
                        r_word_c  = view_flat[8*8 +: 32];
                        r_word_d  = view_flat[8*12 +: 32];
                        r_relay   = !client_mode_reg;
                    end
                end
                TYPE_LEAVE:
                begin
                    if (dec_len != LEAVE_SIZE)
                    begin
                        r_verdict = V_BAD_LENGTH;
                        dead_next = 1'b1;
                    end
                    else
                    begin
                        r_player_id = leave_id;
                        if ({1'b0, leave_id} < MAX_PLAYERS_W && !leave_is_local)
                        begin
                            r_verdict = V_LEAVE_CLEAR;
                        end
                        else
                        begin
                            r_verdict = V_LEAVE_IGNORED;
                        end
                    end
                end
                default:
                begin
                    r_verdict = V_UNKNOWN_TYPE;
                    dead_next = 1'b1;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_mode_reg      <= 1'b0;
            link_player_id_reg   <= 2'd0;
            expected_magic_reg   <= 32'd0;
            protocol_version_reg <= 16'd0;
            game_build_reg       <= 32'd0;
            generator_build_reg  <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLIENT_MODE:      client_mode_reg      <= cfg_data[0];
                CFG_LINK_PLAYER_ID:   link_player_id_reg   <= cfg_data[1:0];
                CFG_EXPECTED_MAGIC:   expected_magic_reg   <= cfg_data;
                CFG_PROTOCOL_VERSION: protocol_version_reg <= cfg_data[15:0];
                CFG_GAME_BUILD:       game_build_reg       <= cfg_data;
                CFG_GENERATOR_BUILD:  generator_build_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg    <= rx_byte;
            in_restart_reg <= link_restart;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TYPE;
            type_reg        <= 8'd0;
            len_reg         <= 16'd0;
            count_reg       <= 16'd0;
            dead_reg        <= 1'b0;
            failed_reg      <= 1'b0;
            local_id_reg    <= '0;
            local_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            type_reg        <= type_next;
            len_reg         <= len_next;
            count_reg       <= count_next;
            dead_reg        <= dead_next;
            failed_reg      <= failed_next;
            local_id_reg    <= local_id_next;
            local_valid_reg <= local_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (advance && store_we && count_reg[STORE_IDX_W-1:0] == STORE_IDX_W'(i))
            begin
                store_reg[i] <= in_byte_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            verdict_reg    <= r_verdict;
            player_id_reg  <= r_player_id;
            word_a_reg     <= r_word_a;
            word_b_reg     <= r_word_b;
            word_c_reg     <= r_word_c;
            word_d_reg     <= r_word_d;
            word_e_reg     <= r_word_e;
            word_f_reg     <= r_word_f;
            world_seed_reg <= r_world_seed;
            relay_reg      <= r_relay;
            dropped_reg    <= dead_next;
            failed_out_reg <= failed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign player_id      = player_id_reg;
    assign word_a         = word_a_reg;
    assign word_b         = word_b_reg;
    assign word_c         = word_c_reg;
    assign word_d         = word_d_reg;
    assign word_e         = word_e_reg;
    assign word_f         = word_f_reg;
    assign world_seed     = world_seed_reg;
    assign relay          = relay_reg;
    assign link_dropped   = dropped_reg;
    assign session_failed = failed_out_reg;

    // A failed session always has its link dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!failed_out_reg || dropped_reg))
        else $error("session failure reported on a live link");

    // An accepted handshake can only be reported on a healthy link.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg == V_HELLO_OK |-> !dropped_reg && !failed_out_reg)
        else $error("hello accepted on a dropped or failed link");

    // Only pose and edit frames are ever relayed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && relay_reg |-> (verdict_reg == V_POSE || verdict_reg == V_EDIT))
        else $error("relay flagged on a frame that is not pose or edit");

    // A dead link without restart produces no new verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && dead_reg && !in_restart_reg |-> !has_result)
        else $error("verdict produced on a dropped link");

endmodule

>>> tb/session_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// Session frame parser core testbench
// Feeds framed link byte streams through the valid/ready input channel and
// checks every verdict request against a cycle-free parser model kept in
// the testbench. A directed frame table comes first, then random frames
// under several register settings and idle patterns, with one long
// receiver stall and drains between settings.
// ----------------------------------------------------------------------------
module session_frame_parser_core_tb;
    import sfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 210;
    localparam int MISS_REPORTS  = 10;
    localparam int DIR_KEEP      = 40;

    typedef enum int {PK_ZERO, PK_ONES, PK_RAND} fill_t;
    typedef enum int {SPOIL_NONE, SPOIL_MAGIC, SPOIL_VERSION, SPOIL_GAME, SPOIL_GEN} spoil_t;
    typedef enum int {PRE_RESET, PRE_HOST3, PRE_CLIENT_MAX} preset_t;

    typedef struct {
        verdict_t          verdict;
        logic [7:0]        pid;
        logic [5:0][31:0]  w;
        logic [63:0]       seed;
        logic              relay;
        logic              dropped;
        logic              failed;
    } frame_rec_t;

    typedef struct {
        preset_t     preset;
        logic        rs;
        logic [7:0]  ftype;
        logic [15:0] len;
        fill_t       fill;
        logic [7:0]  id;
        spoil_t      spoil;
        logic        typed;
        verdict_t    verdict;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        link_restart;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  verdict;
    logic [7:0]  player_id;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [31:0] word_e;
    logic [31:0] word_f;
    logic [63:0] world_seed;
    logic        relay;
    logic        link_dropped;
    logic        session_failed;

    session_frame_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .link_restart   (link_restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .verdict        (verdict),
        .player_id      (player_id),
        .word_a         (word_a),
        .word_b         (word_b),
        .word_c         (word_c),
        .word_d         (word_d),
        .word_e         (word_e),
        .word_f         (word_f),
        .world_seed     (world_seed),
        .relay          (relay),
        .link_dropped   (link_dropped),
        .session_failed (session_failed)
    );

    // Register copies.
    logic        cfg_client;
    logic [1:0]  cfg_link_id;
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [31:0] cfg_game;
    logic [31:0] cfg_gen;

    // Parser model state.
    phase_t      ph;
    logic [7:0]  cur_type;
    logic [15:0] cur_len;
    logic [15:0] got;
    logic [7:0]  pl_buf [STORE_DEPTH];
    logic        link_dead;
    logic        sess_failed;
    logic [7:0]  my_id;
    logic        my_id_valid;

    frame_rec_t  pending_verdicts [$];
    logic [7:0]  frame_bytes [$];
    dir_row_t    plan [$];

    int          mism_count;
    int          live_bytes;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          stall_asks;
    logic        typed_pending;
    verdict_t    typed_v;
    logic        need_restart;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] w32(int at);
        return {pl_buf[(at + 3) % STORE_DEPTH], pl_buf[(at + 2) % STORE_DEPTH],
                pl_buf[(at + 1) % STORE_DEPTH], pl_buf[at % STORE_DEPTH]};
    endfunction

    function automatic void reset_parse();
        ph       = PH_TYPE;
        cur_type = '0;
        cur_len  = '0;
        got      = '0;
    endfunction

    // Decides a complete frame and updates the drop, failure and local id marks.
    function automatic void judge_frame(inout frame_rec_t rec);
        logic [7:0] id;
        logic       mine;
        case (cur_type)
            TYPE_HELLO:
            begin
                if (!cfg_client)
                begin
                    rec.verdict = V_HELLO_WRONG_MODE;
                    link_dead = 1'b1;
                end
                else if (cur_len != HELLO_SIZE)
                begin
                    rec.verdict = V_BAD_LENGTH;
                    link_dead = 1'b1;
                end
                else if (w32(0) != cfg_magic || w32(4) % 32'h10000 != {16'h0, cfg_version}
                         || w32(6) != cfg_game || w32(10) != cfg_gen)
                begin
                    rec.verdict = V_VERSION_REFUSED;
                    link_dead = 1'b1;
                    sess_failed = 1'b1;
                end
                else
                begin
                    rec.pid = pl_buf[22];
                    if (pl_buf[22] < 1 || pl_buf[22] >= MAX_PLAYERS)
                    begin
                        rec.verdict = V_HELLO_BAD_ID;
                        link_dead = 1'b1;
                        sess_failed = 1'b1;
                    end
                    else
                    begin
                        rec.verdict = V_HELLO_OK;
                        rec.seed = {w32(18), w32(14)};
                        my_id = pl_buf[22];
                        my_id_valid = 1'b1;
                    end
                end
            end
            TYPE_POSE:
            begin
                if (cur_len != POSE_SIZE)
                begin
                    rec.verdict = V_BAD_LENGTH;
                    link_dead = 1'b1;
                end
                else
                begin
                    id = cfg_client ? pl_buf[0] : {6'h0, cfg_link_id};
                    rec.pid = id;
                    if (id >= MAX_PLAYERS)
                    begin
                        rec.verdict = V_POSE_BAD_ID;
                        link_dead = 1'b1;
                    end
                    else
                    begin
                        rec.verdict = V_POSE;
                        for (int k = 0; k < 6; k++)
                            rec.w[k] = w32(1 + 4 * k);
                        rec.relay = !cfg_client;
                    end
                end
            end
            TYPE_EDIT:
            begin
                if (cur_len != EDIT_SIZE)
                begin
                    rec.verdict = V_BAD_LENGTH;
                    link_dead = 1'b1;
                end
                else
                begin
                    rec.verdict = V_EDIT;
                    for (int k = 0; k < 4; k++)
                        rec.w[k] = w32(4 * k);
                    rec.relay = !cfg_client;
                end
            end
            TYPE_LEAVE:
            begin
                if (cur_len != LEAVE_SIZE)
                begin
                    rec.verdict = V_BAD_LENGTH;
                    link_dead = 1'b1;
                end
                else
                begin
                    id = pl_buf[0];
                    rec.pid = id;
                    mine = cfg_client ? (my_id_valid && id == my_id) : (id == 8'h0);
                    rec.verdict = (id < MAX_PLAYERS && !mine) ? V_LEAVE_CLEAR : V_LEAVE_IGNORED;
                end
            end
            default:
            begin
                rec.verdict = V_UNKNOWN_TYPE;
                link_dead = 1'b1;
            end
        endcase
    endfunction

    // Advances the parser model by one accepted byte.
    function automatic void parse_byte(input logic [7:0] b, input logic rs,
                                       output logic live, output logic has,
                                       output frame_rec_t rec);
        rec.verdict = V_HELLO_OK;
        rec.pid     = '0;
        rec.w       = '0;
        rec.seed    = '0;
        rec.relay   = 1'b0;
        rec.dropped = 1'b0;
        rec.failed  = 1'b0;
        has = 1'b0;
        if (rs)
        begin
            reset_parse();
            link_dead = 1'b0;
            sess_failed = 1'b0;
        end
        live = !link_dead;
        if (link_dead)
            return;
        case (ph)
            PH_TYPE:
            begin
                cur_type = b;
                ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                cur_len = {8'h0, b};
                ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                cur_len[15:8] = b;
                if (int'(cur_len) + 3 > RECV_CAPACITY)
                begin
                    rec.verdict = V_OVERSIZE;
                    link_dead = 1'b1;
                    reset_parse();
                    has = 1'b1;
                end
                else if (cur_len == 16'h0)
                begin
                    judge_frame(rec);
                    reset_parse();
                    has = 1'b1;
                end
                else
                begin
                    ph = PH_PAYLOAD;
                    got = '0;
                end
            end
            default:
            begin
                if (got < STORE_DEPTH)
                    pl_buf[got] = b;
                got = got + 16'h1;
                if (got == cur_len)
                begin
                    judge_frame(rec);
                    reset_parse();
                    has = 1'b1;
                end
            end
        endcase
        rec.dropped = link_dead;
        rec.failed  = sess_failed;
    endfunction

    task automatic report_miss(input string what, input logic [63:0] want,
                               input logic [63:0] seen);
        mism_count++;
        if (mism_count <= MISS_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
    endtask

    // Offers one byte request and waits for its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        logic       took;
        logic       live;
        logic       has;
        frame_rec_t rec;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        link_restart <= rs;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        parse_byte(b, rs, live, has, rec);
        if (live)
            live_bytes++;
        if (has)
        begin
            if (typed_pending)
            begin
                rec.verdict = typed_v;
                typed_pending = 1'b0;
            end
            pending_verdicts.push_back(rec);
        end
    endtask

    // Stops offering bytes until every verdict has come out and the pipe is empty.
    task automatic settle_link();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic cm, input logic [1:0] lid, input logic [31:0] magic,
                                input logic [15:0] ver, input logic [31:0] game,
                                input logic [31:0] gen);
        logic [31:0] vals [6];
        logic [2:0]  idx  [6];
        vals = '{{31'h0, cm}, {30'h0, lid}, magic, {16'h0, ver}, game, gen};
        idx  = '{CFG_CLIENT_MODE, CFG_LINK_PLAYER_ID, CFG_EXPECTED_MAGIC,
                 CFG_PROTOCOL_VERSION, CFG_GAME_BUILD, CFG_GENERATOR_BUILD};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cfg_client  = cm;
        cfg_link_id = lid;
        cfg_magic   = magic;
        cfg_version = ver;
        cfg_game    = game;
        cfg_gen     = gen;
    endtask

    task automatic load_preset(input preset_t p);
        case (p)
            PRE_HOST3:
                apply_config(1'b0, 2'd3, $urandom, 16'($urandom), $urandom, $urandom);
            PRE_CLIENT_MAX:
                apply_config(1'b1, 2'd0, 32'hffff_ffff, 16'hffff, 32'h0, 32'hffff_ffff);
            default:
                apply_config(1'b0, 2'd0, 32'h0, 16'h0, 32'h0, 32'h0);
        endcase
    endtask

    // Builds a payload; a full-length HELLO carries the current handshake fields.
    task automatic make_payload(input fill_t fl, input logic [7:0] ft, input logic [15:0] len,
                                input logic [7:0] id, input spoil_t sp);
        int at;
        frame_bytes.delete();
        for (int i = 0; i < int'(len); i++)
        begin
            case (fl)
                PK_ZERO: frame_bytes.push_back(8'h00);
                PK_ONES: frame_bytes.push_back(8'hff);
                default: frame_bytes.push_back(8'($urandom));
            endcase
        end
        if (ft == TYPE_HELLO && len == HELLO_SIZE)
        begin
            for (int k = 0; k < 4; k++)
            begin
                frame_bytes[k]      = cfg_magic[8 * k +: 8];
                frame_bytes[6 + k]  = cfg_game[8 * k +: 8];
                frame_bytes[10 + k] = cfg_gen[8 * k +: 8];
            end
            frame_bytes[4]  = cfg_version[7:0];
            frame_bytes[5]  = cfg_version[15:8];
            frame_bytes[22] = id;
            case (sp)
                SPOIL_MAGIC:   at = $urandom_range(0, 3);
                SPOIL_VERSION: at = $urandom_range(4, 5);
                SPOIL_GAME:    at = $urandom_range(6, 9);
                SPOIL_GEN:     at = $urandom_range(10, 13);
                default:       at = -1;
            endcase
            if (at >= 0)
                frame_bytes[at] = frame_bytes[at] ^ 8'(1 << $urandom_range(0, 7));
        end
        else if ((ft == TYPE_POSE || ft == TYPE_LEAVE) && len != 16'h0)
            frame_bytes[0] = id;
    endtask

    // Sends header and up to keep payload bytes (all when keep is negative), none after an oversize header.
    task automatic send_frame(input logic [7:0] ft, input logic [15:0] len, input logic rs,
                              input int keep);
        int n;
        send_byte(ft, rs);
        send_byte(len[7:0], 1'b0);
        send_byte(len[15:8], 1'b0);
        n = (int'(len) + 3 > RECV_CAPACITY) ? 0 : frame_bytes.size();
        if (keep >= 0 && keep < n)
            n = keep;
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i], 1'b0);
    endtask

    task automatic random_frame();
        logic [7:0]  ft;
        logic [7:0]  id;
        logic [15:0] len;
        fill_t       fl;
        spoil_t      sp;
        int          sel;
        int          keep;
        logic        rs;
        // Noise into a dead link is ignored by the block.
        if (link_dead && $urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        rs = link_dead || need_restart || ($urandom_range(99) < 3);
        need_restart = 1'b0;
        case ($urandom_range(0, 19))
            0:       fl = PK_ZERO;
            1:       fl = PK_ONES;
            default: fl = PK_RAND;
        endcase
        sp   = SPOIL_NONE;
        id   = 8'($urandom_range(0, 3));
        keep = -1;
        sel  = $urandom_range(0, 99);
        if (sel < 18)
        begin
            ft  = TYPE_HELLO;
            len = HELLO_SIZE;
            id  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 3)) : 8'($urandom);
            if ($urandom_range(0, 4) == 0)
                sp = spoil_t'($urandom_range(1, 4));
        end
        else if (sel < 45)
        begin
            ft  = TYPE_POSE;
            len = POSE_SIZE;
            if ($urandom_range(0, 9) < 2)
                id = 8'($urandom);
        end
        else if (sel < 65)
        begin
            ft  = TYPE_EDIT;
            len = EDIT_SIZE;
        end
        else if (sel < 82)
        begin
            ft  = TYPE_LEAVE;
            len = LEAVE_SIZE;
            id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        end
        else if (sel < 92)
        begin
            ft  = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(5, 255));
            len = 16'($urandom_range(0, 30));
        end
        else if (sel < 96)
        begin
            ft  = 8'($urandom);
            len = 16'($urandom_range(RECV_CAPACITY - 2, 65535));
        end
        else
        begin
            // Frame cut short; the next one starts a new link.
            ft   = 8'($urandom_range(1, 4));
            len  = 16'($urandom_range(2, 30));
            keep = $urandom_range(0, int'(len) - 1);
            need_restart = 1'b1;
        end
        if (sel < 82 && $urandom_range(0, 9) == 0)
            len = 16'($urandom_range(0, 40));
        make_payload(fl, ft, len, id, sp);
        send_frame(ft, len, rs, keep);
    endtask

    // Receiver side: random back-pressure plus one long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        int stall_seen;
        hold_left  = 0;
        stall_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != stall_seen)
            begin
                stall_seen = stall_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Outputs are stable at the falling edge; a request seen there is taken at the next rise.
    initial
    begin : monitor
        frame_rec_t       e;
        logic [5:0][31:0] seen_w;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                    report_miss("unexpected verdict request", 64'h0, 64'(verdict));
                else
                begin
                    e = pending_verdicts.pop_front();
                    seen_w = {word_f, word_e, word_d, word_c, word_b, word_a};
                    if (verdict !== e.verdict)
                        report_miss("verdict", 64'(e.verdict), 64'(verdict));
                    if (player_id !== e.pid)
                        report_miss("player_id", 64'(e.pid), 64'(player_id));
                    for (int k = 0; k < 6; k++)
                        if (seen_w[k] !== e.w[k])
                            report_miss($sformatf("word %0d", k), 64'(e.w[k]), 64'(seen_w[k]));
                    if (world_seed !== e.seed)
                        report_miss("world_seed", e.seed, world_seed);
                    if (relay !== e.relay)
                        report_miss("relay", 64'(e.relay), 64'(relay));
                    if (link_dropped !== e.dropped)
                        report_miss("link_dropped", 64'(e.dropped), 64'(link_dropped));
                    if (session_failed !== e.failed)
                        report_miss("session_failed", 64'(e.failed), 64'(session_failed));
                end
            end
        end
    end

    initial
    begin : stimulus
        preset_t cur_preset;
        int      start;
        logic    held;
        dir_row_t r;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_CLIENT_MODE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        rx_byte      <= '0;
        link_restart <= 1'b0;
        cfg_client   = 1'b0;
        cfg_link_id  = '0;
        cfg_magic    = '0;
        cfg_version  = '0;
        cfg_game     = '0;
        cfg_gen      = '0;
        reset_parse();
        for (int i = 0; i < STORE_DEPTH; i++)
            pl_buf[i] = 8'h0;
        link_dead     = 1'b0;
        sess_failed   = 1'b0;
        my_id         = '0;
        my_id_valid   = 1'b0;
        mism_count    = 0;
        live_bytes    = 0;
        stall_asks    = 0;
        typed_pending = 1'b0;
        typed_v       = V_HELLO_OK;
        need_restart  = 1'b0;
        snd_idle_pct  = 38;
        rcv_idle_pct  = 47;
        held          = 1'b0;

        // Host side with reset register values.
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd1,
                                  SPOIL_NONE, 1'b1, V_HELLO_WRONG_MODE});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, TYPE_POSE, POSE_SIZE, PK_ZERO, 8'd0,
                                  SPOIL_NONE, 1'b0, V_POSE});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_POSE, POSE_SIZE, PK_ONES, 8'hff,
                                  SPOIL_NONE, 1'b0, V_POSE});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_LEAVE, LEAVE_SIZE, PK_ZERO, 8'd0,
                                  SPOIL_NONE, 1'b1, V_LEAVE_IGNORED});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_LEAVE, LEAVE_SIZE, PK_RAND, 8'd2,
                                  SPOIL_NONE, 1'b1, V_LEAVE_CLEAR});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_LEAVE, LEAVE_SIZE, PK_ONES, 8'hff,
                                  SPOIL_NONE, 1'b1, V_LEAVE_IGNORED});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_EDIT, EDIT_SIZE, PK_ONES, 8'd0,
                                  SPOIL_NONE, 1'b0, V_EDIT});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_EDIT, 16'd0, PK_ZERO, 8'd0,
                                  SPOIL_NONE, 1'b1, V_BAD_LENGTH});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, 8'h00, 16'd0, PK_ZERO, 8'd0,
                                  SPOIL_NONE, 1'b1, V_UNKNOWN_TYPE});
        // The largest frame that fits must not count as oversize; it is cut
        // short and the next row starts a new link.
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, 8'hff, 16'(RECV_CAPACITY - 3), PK_RAND,
                                  8'd0, SPOIL_NONE, 1'b0, V_UNKNOWN_TYPE});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, TYPE_POSE, 16'(RECV_CAPACITY - 2), PK_RAND,
                                  8'd0, SPOIL_NONE, 1'b1, V_OVERSIZE});
        // The link is dead here, so this frame must give nothing.
        plan.push_back(dir_row_t'{PRE_RESET, 1'b0, TYPE_LEAVE, LEAVE_SIZE, PK_RAND, 8'd1,
                                  SPOIL_NONE, 1'b0, V_LEAVE_CLEAR});
        plan.push_back(dir_row_t'{PRE_RESET, 1'b1, TYPE_HELLO, 16'hffff, PK_RAND, 8'd1,
                                  SPOIL_NONE, 1'b1, V_OVERSIZE});
        // Host side bound to the highest id.
        plan.push_back(dir_row_t'{PRE_HOST3, 1'b1, TYPE_POSE, POSE_SIZE, PK_RAND, 8'd0,
                                  SPOIL_NONE, 1'b0, V_POSE});
        plan.push_back(dir_row_t'{PRE_HOST3, 1'b0, TYPE_POSE, 16'd24, PK_RAND, 8'd0,
                                  SPOIL_NONE, 1'b1, V_BAD_LENGTH});
        // Client side with the extreme handshake values.
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_ZERO, 8'd1,
                                  SPOIL_NONE, 1'b1, V_HELLO_OK});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b0, TYPE_HELLO, HELLO_SIZE, PK_ONES, 8'd3,
                                  SPOIL_NONE, 1'b1, V_HELLO_OK});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b0, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd0,
                                  SPOIL_NONE, 1'b1, V_HELLO_BAD_ID});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd4,
                                  SPOIL_NONE, 1'b1, V_HELLO_BAD_ID});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd1,
                                  SPOIL_MAGIC, 1'b1, V_VERSION_REFUSED});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd1,
                                  SPOIL_VERSION, 1'b1, V_VERSION_REFUSED});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd1,
                                  SPOIL_GAME, 1'b1, V_VERSION_REFUSED});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, HELLO_SIZE, PK_RAND, 8'd1,
                                  SPOIL_GEN, 1'b1, V_VERSION_REFUSED});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_HELLO, 16'd22, PK_RAND, 8'd1,
                                  SPOIL_NONE, 1'b1, V_BAD_LENGTH});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_POSE, POSE_SIZE, PK_RAND, 8'd3,
                                  SPOIL_NONE, 1'b0, V_POSE});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b0, TYPE_POSE, POSE_SIZE, PK_RAND, 8'd4,
                                  SPOIL_NONE, 1'b1, V_POSE_BAD_ID});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b1, TYPE_LEAVE, LEAVE_SIZE, PK_RAND, 8'd3,
                                  SPOIL_NONE, 1'b1, V_LEAVE_IGNORED});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b0, TYPE_LEAVE, LEAVE_SIZE, PK_RAND, 8'd1,
                                  SPOIL_NONE, 1'b1, V_LEAVE_CLEAR});
        plan.push_back(dir_row_t'{PRE_CLIENT_MAX, 1'b0, TYPE_EDIT, EDIT_SIZE, PK_ZERO, 8'd0,
                                  SPOIL_NONE, 1'b0, V_EDIT});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_preset = PRE_RESET;
        foreach (plan[i])
        begin
            r = plan[i];
            if (r.preset != cur_preset)
            begin
                settle_link();
                load_preset(r.preset);
                cur_preset = r.preset;
            end
            make_payload(r.fill, r.ftype, r.len, r.id, r.spoil);
            typed_pending = r.typed;
            typed_v       = r.verdict;
            send_frame(r.ftype, r.len, r.rs, DIR_KEEP);
            typed_pending = 1'b0;
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                settle_link();
                snd_idle_pct = (stage == 0) ? 38 : (stage == 1) ? 47 : 0;
                rcv_idle_pct = (stage == 0) ? 47 : (stage == 1) ? 38 : 0;
                apply_config(half[0], 2'($urandom), $urandom, 16'($urandom), $urandom,
                             $urandom);
                start = live_bytes;
                while (live_bytes - start < PHASE_BYTES)
                begin
                    if (!held && live_bytes - start > 60)
                    begin
                        stall_asks++;
                        held = 1'b1;
                    end
                    random_frame();
                end
            end
        end

        settle_link();
        repeat (10) @(posedge clk);
        if (mism_count == 0 && pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> session_frame_parser_core.f
sv/sfp_pkg.sv
sv/session_frame_parser_core.sv
tb/session_frame_parser_core_tb.sv
